// ===== src/vrrb_pkg.sv =====
// shared constants, codes and types for the variable record ring buffer
package vrrb_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int HDR_ADDR_W   = $clog2(RING_BYTES);
    localparam int MIN_RING     = 64;

    // operation codes
    localparam logic [1:0] FN_RESERVE = 2'd0;
    localparam logic [1:0] FN_COMMIT  = 2'd1;
    localparam logic [1:0] FN_PEEK    = 2'd2;
    localparam logic [1:0] FN_RELEASE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTREADY = 3'd3;
    localparam logic [2:0] ST_BADLEN   = 3'd4;
    localparam logic [2:0] ST_WRONGOFS = 3'd5;
    localparam logic [2:0] ST_HELD     = 3'd6;

    typedef struct packed {
        logic        ready;
        logic [12:0] len;
    } t_hdr;

    typedef struct packed {
        logic                  we;
        logic [HDR_ADDR_W-1:0] waddr;
        t_hdr                  wdata;
        logic [HDR_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== src/vrrb_if.sv =====
// channel interfaces: request, response and ring size write
interface vrrb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [12:0] req_length;
    logic [11:0] payload_offset;

    modport source (output valid, output func, output req_length, output payload_offset,
                    input ready);
    modport sink (input valid, input func, input req_length, input payload_offset,
                  output ready);
endinterface

interface vrrb_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [11:0] out_offset;
    logic [12:0] out_length;

    modport source (output valid, output status, output out_offset, output out_length,
                    input ready);
    modport sink (input valid, input status, input out_offset, input out_length,
                  output ready);
endinterface

interface vrrb_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] ring_bytes;

    modport source (output valid, output ring_bytes, input ready);
    modport sink (input valid, input ring_bytes, output ready);
endinterface

// ===== src/vrrb_hdr_mem.sv =====
// header store: one write port, one read port, registered read data
module vrrb_hdr_mem
    import vrrb_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_hdr     o_rdata
);

    t_hdr r_mem [RING_BYTES];
    t_hdr r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/variable_record_ring_buffer.sv =====
// top level: record ring buffer controller around the header store
//
//  channel | dir | payload                            | beat when
//  i_req   | in  | func, req_length, payload_offset   | valid & ready
//  o_rsp   | out | status, out_offset, out_length     | valid & ready
//  i_cfg   | in  | ring_bytes                         | valid & ready
//
// an operation is accepted with its header read issued, then evaluated and written
// back; reserve with a wrap and peek across a skip header evaluate again, since each
// extra header write or read needs its own pass through the header store port.
// reset (i_rst_n low, synchronous) empties the ring and sets ring_bytes to 4096;
// the header store is not cleared. a full response register holds the
// evaluate step until the response beat is taken.
module variable_record_ring_buffer
    import vrrb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    vrrb_req_if.sink   i_req,
    vrrb_rsp_if.source o_rsp,
    vrrb_cfg_if.sink   i_cfg
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic        r_state, n_state;
    logic        r_pass, n_pass;
    logic [12:0] r_ring_bytes, n_ring_bytes;
    logic [12:0] r_write_head, n_write_head;
    logic [12:0] r_read_head, n_read_head;
    logic        r_held, n_held;
    logic [12:0] r_raddr, n_raddr;
    logic        r_rd_zero;

    logic [1:0]  r_func;
    logic [12:0] r_len;
    logic [11:0] r_ofs;

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [11:0] r_out_offset;
    logic [12:0] r_out_length;

    logic        in_beat, cfg_beat, out_free, done;
    logic [2:0]  res_status;
    logic [11:0] res_ofs;
    logic [12:0] res_len;
    logic [12:0] cfg_sat;
    logic [13:0] free_bytes, needed, total, rel_total;
    logic [12:0] ofs_hdr;
    logic        ofs_low;
    t_hdr        rdata, hdr;
    t_mem_req    mem_req;

    assign i_req.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign in_beat     = i_req.valid && i_req.ready;
    assign cfg_beat    = i_cfg.valid && i_cfg.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.out_offset = r_out_offset;
    assign o_rsp.out_length = r_out_length;

    vrrb_hdr_mem u_hdr_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    // offsets past the store read as an empty header
    assign hdr = r_rd_zero ? '0 : rdata;

    always_comb begin
        if (i_cfg.ring_bytes < 13'(MIN_RING)) begin
            cfg_sat = 13'(MIN_RING);
        end else if (i_cfg.ring_bytes > 13'(RING_BYTES)) begin
            cfg_sat = 13'(RING_BYTES);
        end else begin
            cfg_sat = i_cfg.ring_bytes;
        end
    end

    always_comb begin
        if (r_write_head >= r_read_head) begin
            free_bytes = 14'(r_ring_bytes) - 14'(r_write_head) + 14'(r_read_head);
        end else begin
            free_bytes = 14'(r_read_head) - 14'(r_write_head);
        end
    end

    assign total     = 14'(r_len) + 14'(HEADER_BYTES);
    assign needed    = total + 14'(HEADER_BYTES);
    assign rel_total = 14'(hdr.len) + 14'(HEADER_BYTES);
    assign ofs_low   = r_ofs < 12'(HEADER_BYTES);
    assign ofs_hdr   = 13'(r_ofs) - 13'(HEADER_BYTES);

    always_comb begin
        n_state      = r_state;
        n_pass       = r_pass;
        n_ring_bytes = r_ring_bytes;
        n_write_head = r_write_head;
        n_read_head  = r_read_head;
        n_held       = r_held;
        n_raddr      = r_raddr;
        mem_req      = '0;
        done         = 1'b0;
        res_status   = ST_OK;
        res_ofs      = '0;
        res_len      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cfg_beat) begin
                    n_ring_bytes = cfg_sat;
                    n_write_head = '0;
                    n_read_head  = '0;
                    n_held       = 1'b0;
                end
                if (in_beat) begin
                    n_state = S_EXEC;
                    n_pass  = 1'b0;
                    if (i_req.func == FN_COMMIT) begin
                        n_raddr = {1'b0, i_req.payload_offset - 12'(HEADER_BYTES)};
                    end else begin
                        n_raddr = r_read_head;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    unique case (r_func)
                        FN_RESERVE: begin
                            if (r_len == '0) begin
                                done       = 1'b1;
                                res_status = ST_BADLEN;
                            end else if (free_bytes < needed) begin
                                done       = 1'b1;
                                res_status = ST_NOSPACE;
                            end else if (14'(r_write_head) + needed > 14'(r_ring_bytes)) begin
                                // skip header at the tail, then retry from offset zero
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_write_head[HDR_ADDR_W-1:0];
                                mem_req.wdata = '{ready: 1'b1, len: '0};
                                n_write_head  = '0;
                                n_pass        = 1'b1;
                            end else begin
                                done          = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_write_head[HDR_ADDR_W-1:0];
                                mem_req.wdata = '{ready: 1'b0, len: r_len};
                                res_ofs       = 12'(r_write_head + 13'(HEADER_BYTES));
                                n_write_head  = 13'(14'(r_write_head) + total);
                            end
                        end
                        FN_COMMIT: begin
                            done = 1'b1;
                            if (ofs_low || ofs_hdr >= r_ring_bytes) begin
                                res_status = ST_WRONGOFS;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ofs_hdr[HDR_ADDR_W-1:0];
                                mem_req.wdata = '{ready: 1'b1, len: hdr.len};
                            end
                        end
                        FN_PEEK: begin
                            if (r_held) begin
                                done       = 1'b1;
                                res_status = ST_HELD;
                            end else if (r_read_head == r_write_head) begin
                                done       = 1'b1;
                                res_status = ST_EMPTY;
                            end else if (!hdr.ready) begin
                                done       = 1'b1;
                                res_status = ST_NOTREADY;
                            end else if (hdr.len == '0) begin
                                n_read_head = '0;
                                if (r_pass) begin
                                    done       = 1'b1;
                                    res_status = ST_NOTREADY;
                                end else begin
                                    // follow the skip header: read offset zero next
                                    n_pass  = 1'b1;
                                    n_raddr = '0;
                                end
                            end else begin
                                done       = 1'b1;
                                res_ofs    = 12'(r_read_head + 13'(HEADER_BYTES));
                                res_len    = hdr.len;
                                n_held     = 1'b1;
                            end
                        end
                        FN_RELEASE: begin
                            done = 1'b1;
                            if (ofs_low || ofs_hdr != r_read_head) begin
                                res_status = ST_WRONGOFS;
                            end else if (r_read_head == r_write_head) begin
                                res_status = ST_EMPTY;
                            end else if (!hdr.ready || hdr.len == '0) begin
                                res_status = ST_NOTREADY;
                            end else begin
                                n_held = 1'b0;
                                if (14'(r_read_head) + rel_total > 14'(r_ring_bytes)) begin
                                    n_read_head = '0;
                                end else begin
                                    n_read_head = 13'(14'(r_read_head) + rel_total);
                                end
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                    if (done) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        mem_req.raddr = n_raddr[HDR_ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pass       <= 1'b0;
            r_ring_bytes <= 13'(RING_BYTES);
            r_write_head <= '0;
            r_read_head  <= '0;
            r_held       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pass       <= n_pass;
            r_ring_bytes <= n_ring_bytes;
            r_write_head <= n_write_head;
            r_read_head  <= n_read_head;
            r_held       <= n_held;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr   <= n_raddr;
        r_rd_zero <= n_raddr[HDR_ADDR_W];
        if (in_beat) begin
            r_func <= i_req.func;
            r_len  <= i_req.req_length;
            r_ofs  <= i_req.payload_offset;
        end
        if (done) begin
            r_status     <= res_status;
            r_out_offset <= res_ofs;
            r_out_length <= res_len;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_state == S_EXEC && !r_pass))
        else $error("accepted beat did not start evaluation");

    a_ring_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring_bytes >= 13'(MIN_RING)) && (r_ring_bytes <= 13'(RING_BYTES)))
        else $error("ring size out of range");

    a_write_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_head <= r_ring_bytes)
        else $error("write head beyond ring");

    a_peek_second_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_pass && r_func == FN_PEEK) |->
            (r_read_head == '0 && r_raddr == '0))
        else $error("second peek pass not at offset zero");

endmodule
